// ===== src/pskk_pkg.sv =====
// ----------------------------------------------------------------------------
// pskk_pkg
// Shared types and constants for the patch SSD k-best match keeper.
// ----------------------------------------------------------------------------
package pskk_pkg;

  // Field widths fixed by the item format.
  localparam int SAMPLE_BITS = 8;
  localparam int COORD_BITS  = 12;
  localparam int T_BITS      = 10;
  localparam int COST_BITS   = 32;
  localparam int K_BITS      = 4;
  localparam int SQ_BITS     = 2 * SAMPLE_BITS;

  // Default number of entry slots and reset value of the k register.
  localparam int KNN_MAX_DEF = 8;
  localparam logic [K_BITS-1:0] K_RESET = K_BITS'(4);

  // Command queue between the front and back parts.
  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  // Input action codes.
  typedef enum logic [1:0] {
    ACT_LOAD   = 2'd0,
    ACT_SAMPLE = 2'd1,
    ACT_FLUSH  = 2'd2
  } action_t;

  // Commands handed from the front part to the back part.
  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_VERDICT = 2'd1,
    CMD_FLUSH   = 2'd2
  } cmd_kind_t;

  // Back part sequencer states.
  typedef enum logic [2:0] {
    BK_IDLE   = 3'd0,
    BK_SCAN   = 3'd1,
    BK_DECIDE = 3'd2,
    BK_FSCAN  = 3'd3,
    BK_FEMIT  = 3'd4
  } bk_state_t;

  typedef struct packed {
    logic [1:0]             action;
    logic [SAMPLE_BITS-1:0] sample_a;
    logic [SAMPLE_BITS-1:0] sample_b;
    logic                   last_sample;
    logic [COORD_BITS-1:0]  cand_x;
    logic [COORD_BITS-1:0]  cand_y;
    logic [T_BITS-1:0]      cand_t;
    logic [COST_BITS-1:0]   load_cost;
  } in_item_t;

  typedef struct packed {
    logic [COST_BITS-1:0]  out_cost;
    logic [COORD_BITS-1:0] out_x;
    logic [COORD_BITS-1:0] out_y;
    logic [T_BITS-1:0]     out_t;
    logic                  accepted;
    logic                  is_flush;
    logic                  last_result;
  } out_item_t;

  // One entry tuple; the packed order gives the (cost, x, y, t) ordering.
  typedef struct packed {
    logic [COST_BITS-1:0]  cost;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [T_BITS-1:0]     t;
  } ent_key_t;

  typedef struct packed {
    cmd_kind_t kind;
    ent_key_t  key;
  } cmd_t;

  // Queue status seen by the front part.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== src/pskk_front.sv =====
// ----------------------------------------------------------------------------
// pskk_front
// Accepts input beats, squares the sample difference into a stage register and
// accumulates the saturating cost from that register, then queues commands.
// ----------------------------------------------------------------------------
module pskk_front import pskk_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  input  q_status_t q_stat,
  output logic      q_push,
  output cmd_t      q_wdata
);

  logic                 s1_valid_r, s1_valid_nxt;
  in_item_t             s1_item_r;
  logic [SQ_BITS-1:0]   sq_r;
  logic [COST_BITS-1:0] cost_sum_r, cost_sum_nxt;

  logic [SAMPLE_BITS-1:0] diff;
  logic [COST_BITS:0]     sum_wide;
  logic [COST_BITS-1:0]   sum_sat;
  logic                   need_push;
  logic                   s1_done;
  logic                   in_fire;

  // Absolute difference of the sample pair.
  always_comb begin
    if (in_data.sample_a >= in_data.sample_b) begin
      diff = in_data.sample_a - in_data.sample_b;
    end else begin
      diff = in_data.sample_b - in_data.sample_a;
    end
  end

  // Saturating accumulation of the registered square.
  assign sum_wide = {1'b0, cost_sum_r} + (COST_BITS + 1)'(sq_r);
  assign sum_sat  = sum_wide[COST_BITS] ? {COST_BITS{1'b1}} : sum_wide[COST_BITS-1:0];

  // Loads, flushes and last samples produce a command for the back part.
  always_comb begin
    case (s1_item_r.action)
      ACT_LOAD:   need_push = 1'b1;
      ACT_SAMPLE: need_push = s1_item_r.last_sample;
      ACT_FLUSH:  need_push = 1'b1;
      default:    need_push = 1'b0;
    endcase
  end

  assign s1_done  = s1_valid_r && (!need_push || !q_stat.full);
  assign q_push   = s1_valid_r && need_push && !q_stat.full;
  assign in_ready = !s1_valid_r || s1_done;
  assign in_fire  = in_valid && in_ready;

  // Command payload.
  always_comb begin
    q_wdata.key.x = s1_item_r.cand_x;
    q_wdata.key.y = s1_item_r.cand_y;
    q_wdata.key.t = s1_item_r.cand_t;
    case (s1_item_r.action)
      ACT_LOAD: begin
        q_wdata.kind     = CMD_LOAD;
        q_wdata.key.cost = s1_item_r.load_cost;
      end
      ACT_FLUSH: begin
        q_wdata.kind     = CMD_FLUSH;
        q_wdata.key.cost = sum_sat;
      end
      default: begin
        q_wdata.kind     = CMD_VERDICT;
        q_wdata.key.cost = sum_sat;
      end
    endcase
  end

  // Next values of the stage and the running cost.
  always_comb begin
    s1_valid_nxt = in_fire ? 1'b1 : (s1_done ? 1'b0 : s1_valid_r);
    cost_sum_nxt = cost_sum_r;
    if (s1_done && s1_item_r.action == ACT_SAMPLE) begin
      cost_sum_nxt = s1_item_r.last_sample ? '0 : sum_sat;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      cost_sum_r <= '0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      cost_sum_r <= cost_sum_nxt;
    end
  end

  // Stage payload.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r <= in_data;
      sq_r      <= SQ_BITS'(diff) * SQ_BITS'(diff);
    end
  end

endmodule

// ===== src/pskk_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// pskk_cmd_fifo
// Short command queue that decouples the front part from the back part.
// ----------------------------------------------------------------------------
module pskk_cmd_fifo import pskk_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  cmd_t      wdata,
  input  logic      pop,
  output cmd_t      rdata,
  output q_status_t stat
);

  cmd_t             mem_r [QDEPTH];
  logic [QAW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]     count_r, count_nxt;

  assign stat.full  = (count_r == (QAW + 1)'(QDEPTH));
  assign stat.empty = (count_r == '0);
  assign rdata      = mem_r[rd_ptr_r];

  // Pointer and fill level update.
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QAW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + QAW'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + (QAW + 1)'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - (QAW + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage write.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ===== src/pskk_back.sv =====
// ----------------------------------------------------------------------------
// pskk_back
// Holds the k entries. Loads write a slot directly; verdicts scan one slot a
// cycle for the worst entry and duplicates; flushes run one minimum pass a
// result. Results leave through an output register.
// ----------------------------------------------------------------------------
module pskk_back import pskk_pkg::*; #(
  parameter int KNN_MAX = KNN_MAX_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [K_BITS-1:0] k_in_use,
  input  logic              q_valid,
  input  cmd_t              q_data,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data
);

  localparam int IDX_W = (KNN_MAX > 1) ? $clog2(KNN_MAX) : 1;
  localparam int CNT_W = $clog2(KNN_MAX + 1);

  // Entry store.
  ent_key_t           ent_r [KNN_MAX];
  logic [KNN_MAX-1:0] valid_r;

  bk_state_t          state_r, state_nxt;
  cmd_t               cmd_r, cmd_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [CNT_W-1:0]   load_count_r, load_count_nxt;
  logic               have_empty_r, have_empty_nxt;
  logic               dup_r, dup_nxt;
  logic               pick_ok_r, pick_ok_nxt;
  logic [IDX_W-1:0]   pick_idx_r, pick_idx_nxt;
  ent_key_t           pick_key_r, pick_key_nxt;
  logic [KNN_MAX-1:0] emitted_r, emitted_nxt;
  logic [1:0]         cnt_r, cnt_nxt;
  logic               out_valid_r;
  out_item_t          out_data_r, out_data_nxt;
  logic               out_load;

  logic               ent_we;
  logic [IDX_W-1:0]   ent_widx;
  ent_key_t           ent_wkey;

  logic [CNT_W-1:0]   k_eff;
  logic               idx_last;
  logic               out_free;
  ent_key_t           key_i;
  logic               v_i;
  logic               same_pos;
  logic               acc;
  logic [CNT_W-1:0]   slot;
  logic [CNT_W-1:0]   slot_inc;

  // Effective k: zero acts as one, above the slot count acts as the count.
  always_comb begin
    if (k_in_use == '0) begin
      k_eff = CNT_W'(1);
    end else if (int'(k_in_use) > KNN_MAX) begin
      k_eff = CNT_W'(KNN_MAX);
    end else begin
      k_eff = CNT_W'(k_in_use);
    end
  end

  // Slot under scan.
  assign key_i    = ent_r[idx_r];
  assign v_i      = valid_r[idx_r];
  assign same_pos = (key_i.x == cmd_r.key.x) && (key_i.y == cmd_r.key.y) &&
                    (key_i.t == cmd_r.key.t);
  assign idx_last = ((CNT_W'(idx_r) + CNT_W'(1)) == k_eff);
  assign out_free = !out_valid_r || out_ready;
  assign acc      = !dup_r && (have_empty_r || (cmd_r.key.cost < pick_key_r.cost));

  // Load slot selection and wrap.
  assign slot     = (load_count_r < k_eff) ? load_count_r : '0;
  assign slot_inc = slot + CNT_W'(1);

  assign q_pop     = (state_r == BK_IDLE) && q_valid;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          case (q_data.kind)
            CMD_VERDICT: state_nxt = BK_SCAN;
            CMD_FLUSH:   state_nxt = BK_FSCAN;
            default:     state_nxt = BK_IDLE;
          endcase
        end
      end
      BK_SCAN: begin
        if (idx_last) state_nxt = BK_DECIDE;
      end
      BK_DECIDE: begin
        if (out_free) state_nxt = BK_IDLE;
      end
      BK_FSCAN: begin
        if (idx_last) state_nxt = BK_FEMIT;
      end
      BK_FEMIT: begin
        if (!pick_ok_r) begin
          state_nxt = BK_IDLE;
        end else if (out_free) begin
          state_nxt = (cnt_r == 2'd1) ? BK_IDLE : BK_FSCAN;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // Datapath and outputs per state.
  always_comb begin
    cmd_nxt        = cmd_r;
    idx_nxt        = idx_r;
    load_count_nxt = load_count_r;
    have_empty_nxt = have_empty_r;
    dup_nxt        = dup_r;
    pick_ok_nxt    = pick_ok_r;
    pick_idx_nxt   = pick_idx_r;
    pick_key_nxt   = pick_key_r;
    emitted_nxt    = emitted_r;
    cnt_nxt        = cnt_r;
    out_load       = 1'b0;
    out_data_nxt   = out_data_r;
    ent_we         = 1'b0;
    ent_widx       = pick_idx_r;
    ent_wkey       = cmd_r.key;
    case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          cmd_nxt        = q_data;
          idx_nxt        = '0;
          have_empty_nxt = 1'b0;
          dup_nxt        = 1'b0;
          pick_ok_nxt    = 1'b0;
          cnt_nxt        = '0;
          emitted_nxt    = '0;
          case (q_data.kind)
            CMD_LOAD: begin
              ent_we         = 1'b1;
              ent_widx       = IDX_W'(slot);
              ent_wkey       = q_data.key;
              load_count_nxt = (slot_inc >= k_eff) ? '0 : slot_inc;
            end
            CMD_FLUSH: begin
              load_count_nxt = '0;
            end
            default: begin
              load_count_nxt = load_count_r;
            end
          endcase
        end
      end
      BK_SCAN: begin
        // Worst search: the first empty slot wins, else the greatest tuple.
        if (v_i) begin
          if (same_pos) dup_nxt = 1'b1;
          if (!have_empty_r && (!pick_ok_r || (key_i > pick_key_r))) begin
            pick_ok_nxt  = 1'b1;
            pick_idx_nxt = idx_r;
            pick_key_nxt = key_i;
          end
        end else if (!have_empty_r) begin
          have_empty_nxt = 1'b1;
          pick_idx_nxt   = idx_r;
        end
        idx_nxt = idx_r + IDX_W'(1);
      end
      BK_DECIDE: begin
        if (out_free) begin
          out_load                 = 1'b1;
          out_data_nxt.out_cost    = cmd_r.key.cost;
          out_data_nxt.out_x       = cmd_r.key.x;
          out_data_nxt.out_y       = cmd_r.key.y;
          out_data_nxt.out_t       = cmd_r.key.t;
          out_data_nxt.accepted    = acc;
          out_data_nxt.is_flush    = 1'b0;
          out_data_nxt.last_result = 1'b1;
          ent_we                   = acc;
        end
      end
      BK_FSCAN: begin
        // Smallest tuple not yet sent; count, up to two, how many remain.
        if (v_i && !emitted_r[idx_r]) begin
          cnt_nxt = (cnt_r == 2'd0) ? 2'd1 : 2'd2;
          if (!pick_ok_r || (key_i < pick_key_r)) begin
            pick_ok_nxt  = 1'b1;
            pick_idx_nxt = idx_r;
            pick_key_nxt = key_i;
          end
        end
        idx_nxt = idx_r + IDX_W'(1);
      end
      BK_FEMIT: begin
        if (pick_ok_r && out_free) begin
          out_load                 = 1'b1;
          out_data_nxt.out_cost    = pick_key_r.cost;
          out_data_nxt.out_x       = pick_key_r.x;
          out_data_nxt.out_y       = pick_key_r.y;
          out_data_nxt.out_t       = pick_key_r.t;
          out_data_nxt.accepted    = 1'b0;
          out_data_nxt.is_flush    = 1'b1;
          out_data_nxt.last_result = (cnt_r == 2'd1);
          emitted_nxt[pick_idx_r]  = 1'b1;
          idx_nxt                  = '0;
          pick_ok_nxt              = 1'b0;
          cnt_nxt                  = '0;
        end
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= BK_IDLE;
      load_count_r <= '0;
      valid_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      load_count_r <= load_count_nxt;
      if (ent_we) valid_r[ent_widx] <= 1'b1;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload and scan registers.
  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    idx_r        <= idx_nxt;
    have_empty_r <= have_empty_nxt;
    dup_r        <= dup_nxt;
    pick_ok_r    <= pick_ok_nxt;
    pick_idx_r   <= pick_idx_nxt;
    pick_key_r   <= pick_key_nxt;
    emitted_r    <= emitted_nxt;
    cnt_r        <= cnt_nxt;
    out_data_r   <= out_data_nxt;
    if (ent_we) ent_r[ent_widx] <= ent_wkey;
  end

endmodule

// ===== src/patch_ssd_knn_keeper_top.sv =====
// ----------------------------------------------------------------------------
// patch_ssd_knn_keeper_top
// Keeps the k best (cost, x, y, t) matches of one target patch.
// ----------------------------------------------------------------------------
// Throughput: one sample beat per cycle unless the queue is full; loads are
// written from the back part's idle state. Verdict path: front stage, queue,
// k-slot scan, decide. Flush: n valid entries in the first k slots give n
// results, each from a one-slot-per-cycle minimum pass and an emit state.
// Reset (synchronous, rst_n low): entries invalid, load count and cost zero,
// k register back to 4.
module patch_ssd_knn_keeper_top import pskk_pkg::*; #(
  parameter int KNN_MAX = KNN_MAX_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [K_BITS-1:0] cfg_data
);

  logic [K_BITS-1:0] k_in_use_r, k_in_use_nxt;
  q_status_t         q_stat;
  logic              q_push;
  logic              q_pop;
  cmd_t              q_wdata;
  cmd_t              q_rdata;

  // Configuration register.
  assign cfg_ready    = 1'b1;
  assign k_in_use_nxt = (cfg_valid && cfg_ready) ? cfg_data : k_in_use_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_in_use_r <= K_RESET;
    end else begin
      k_in_use_r <= k_in_use_nxt;
    end
  end

  pskk_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  pskk_cmd_fifo u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  pskk_back #(
    .KNN_MAX (KNN_MAX)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .k_in_use  (k_in_use_r),
    .q_valid   (!q_stat.empty),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // A verdict is always the final result of its item.
  a_verdict_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.is_flush |-> out_data.last_result)
    else $error("verdict beat without last_result");

  // A flushed entry never reports acceptance.
  a_flush_not_acc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.is_flush |-> !out_data.accepted)
    else $error("flushed beat marked accepted");

  // Reset empties the output register.
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // The back part only pops a command that is present.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("command popped from empty queue");

endmodule
